FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; the using scope provides clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// check outside reset only
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: sv/ucd_pkg.sv
// ----------------------------------------------------------------------------
// Cycle detect package
// Word types, command codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ucd_pkg;

  localparam int KW  = 2;
  localparam int VIW = 10;
  localparam int VCW = 11;

  localparam logic [KW-1:0] KIND_ADD   = 2'd0;
  localparam logic [KW-1:0] KIND_CHECK = 2'd1;
  localparam logic [KW-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [KW-1:0]  kind;
    logic [VIW-1:0] vertex_a;
    logic [VIW-1:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic has_cycle;
    logic load_error;
  } out_word_t;

  typedef struct packed {
    logic sweep;
    logic sweep_deg;
    logic sweep_mark;
    logic load;
    logic edge_w1;
    logic edge_w2;
    logic set_err;
    logic clr_err;
    logic root;
    logic pop;
    logic fetch;
    logic take_par;
    logic nread;
    logic mread;
    logic visit;
    logic report;
    logic found;
  } ucd_cmd_t;

  typedef struct packed {
    logic [KW-1:0] kind;
    logic          sweep_last;
    logic          n_zero;
    logic          edge_bad;
    logic          stack_empty;
    logic          slot_end;
    logic          nbr_skip;
    logic          nbr_visited;
    logic          nbr_parent;
  } ucd_sts_t;

endpackage

FILE: sv/ucd_ctrl.sv
// ----------------------------------------------------------------------------
// Cycle detect controller
// Sequences clearing passes, edge loads and the depth-first walk.
// ----------------------------------------------------------------------------
module ucd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ucd_pkg::ucd_sts_t sts,
  output ucd_pkg::ucd_cmd_t cmd,
  output logic              busy
);
  import ucd_pkg::*;

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_E1    = 4'd2;
  localparam logic [3:0] ST_E2    = 4'd3;
  localparam logic [3:0] ST_CLR   = 4'd4;
  localparam logic [3:0] ST_MCLR  = 4'd5;
  localparam logic [3:0] ST_ROOT  = 4'd6;
  localparam logic [3:0] ST_POP   = 4'd7;
  localparam logic [3:0] ST_FETCH = 4'd8;
  localparam logic [3:0] ST_PINFO = 4'd9;
  localparam logic [3:0] ST_NREAD = 4'd10;
  localparam logic [3:0] ST_NCHK  = 4'd11;
  localparam logic [3:0] ST_VIS   = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_deg  = 1'b1;
        cmd.sweep_mark = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          unique case (sts.kind)
            KIND_ADD: begin
              cmd.load  = 1'b1;
              state_nxt = ST_E1;
            end
            KIND_CHECK: begin
              if (sts.n_zero) begin
                cmd.report = 1'b1;
                cmd.found  = 1'b1;
              end else begin
                state_nxt = ST_MCLR;
              end
            end
            KIND_CLEAR: begin
              cmd.clr_err = 1'b1;
              state_nxt   = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_E1: begin
        if (sts.edge_bad) begin
          cmd.set_err = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.edge_w1 = 1'b1;
          state_nxt   = ST_E2;
        end
      end
      ST_E2: begin
        cmd.edge_w2 = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_CLR: begin
        cmd.sweep     = 1'b1;
        cmd.sweep_deg = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_MCLR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_mark = 1'b1;
        if (sts.sweep_last) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root  = 1'b1;
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sts.stack_empty) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_PINFO;
      end
      ST_PINFO: begin
        cmd.take_par = 1'b1;
        state_nxt    = ST_NREAD;
      end
      ST_NREAD: begin
        if (sts.slot_end) begin
          state_nxt = ST_POP;
        end else begin
          cmd.nread = 1'b1;
          state_nxt = ST_NCHK;
        end
      end
      ST_NCHK: begin
        if (sts.nbr_skip) begin
          state_nxt = ST_NREAD;
        end else begin
          cmd.mread = 1'b1;
          state_nxt = ST_VIS;
        end
      end
      ST_VIS: begin
        if (!sts.nbr_visited) begin
          cmd.visit = 1'b1;
          state_nxt = ST_NREAD;
        end else if (!sts.nbr_parent) begin
          cmd.report = 1'b1;
          cmd.found  = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_NREAD;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

FILE: sv/ucd_dp.sv
// ----------------------------------------------------------------------------
// Cycle detect datapath
// Adjacency, degree, mark and stack memories with walk counters and flags.
// ----------------------------------------------------------------------------
module ucd_dp #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ucd_pkg::in_word_t      in_word,
  input  logic                   cfg_valid,
  input  logic [ucd_pkg::VCW-1:0] cfg_data,
  input  ucd_pkg::ucd_cmd_t      cmd,
  output ucd_pkg::ucd_sts_t      sts,
  output logic                   out_valid,
  output ucd_pkg::out_word_t     out_word
);
  import ucd_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int PW  = $clog2(MAX_VERTICES + 1);
  localparam int DGW = $clog2(MAX_DEGREE + 1);
  localparam int NA  = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int NW  = (VW > VCW) ? VW : VCW;

  localparam logic [VCW-1:0] CAP = (MAX_VERTICES >= (1 << VCW)) ? {VCW{1'b1}}
                                                                : VCW'(MAX_VERTICES);
  localparam logic [PW-1:0]  NO_PARENT  = PW'(MAX_VERTICES);
  localparam logic [DGW-1:0] DEG_MAX    = DGW'(MAX_DEGREE);
  localparam logic [NA-1:0]  DEG_STRIDE = NA'(MAX_DEGREE);
  localparam logic [PW-1:0]  STACK_CAP  = PW'(MAX_VERTICES);
  localparam logic [VW-1:0]  SWEEP_LAST = VW'(MAX_VERTICES - 1);

  logic [DGW-1:0] deg_mem   [MAX_VERTICES];
  logic [VW-1:0]  nbr_mem   [MAX_VERTICES * MAX_DEGREE];
  logic [PW:0]    mark_mem  [MAX_VERTICES];
  logic [VW-1:0]  stack_mem [MAX_VERTICES];

  logic [VCW-1:0] vcount_r;
  logic           err_r;
  logic [VIW-1:0] a_r;
  logic [VIW-1:0] b_r;
  logic [VW-1:0]  sweep_r;
  logic [PW-1:0]  sp_r;
  logic [DGW-1:0] slot_r;
  logic [PW-1:0]  par_r;
  logic           out_valid_r;
  out_word_t      out_word_r;

  logic [DGW-1:0] deg_a_rd_r;
  logic [DGW-1:0] deg_b_rd_r;
  logic [VW-1:0]  nbr_rd_r;
  logic [PW:0]    mark_rd_r;
  logic [VW-1:0]  stk_rd_r;

  logic [VCW-1:0] n_use;
  logic [VW-1:0]  vtx_a;
  logic [VW-1:0]  vtx_b;
  logic           self_loop;
  logic [DGW-1:0] deg_b_eff;
  logic           range_bad;
  logic           deg_bad;
  logic           push_ok;
  logic [PW-1:0]  sp_dec;

  logic           deg_we;
  logic [VW-1:0]  deg_wa;
  logic [DGW-1:0] deg_wd;
  logic [VW-1:0]  deg_ra;
  logic           nbr_we;
  logic [NA-1:0]  nbr_wa;
  logic [VW-1:0]  nbr_wd;
  logic [NA-1:0]  nbr_ra;
  logic           mark_we;
  logic [VW-1:0]  mark_wa;
  logic [PW:0]    mark_wd;
  logic [VW-1:0]  mark_ra;
  logic           stk_we;
  logic [VW-1:0]  stk_wa;
  logic [VW-1:0]  stk_wd;

  assign n_use     = (vcount_r > CAP) ? CAP : vcount_r;
  assign vtx_a     = VW'(a_r);
  assign vtx_b     = VW'(b_r);
  assign self_loop = (a_r == b_r);
  assign deg_b_eff = self_loop ? DGW'(deg_a_rd_r + 1'b1) : deg_b_rd_r;
  assign range_bad = (VCW'(a_r) >= n_use) || (VCW'(b_r) >= n_use);
  assign deg_bad   = self_loop ? (({1'b0, deg_a_rd_r} + (DGW+1)'(2)) > {1'b0, DEG_MAX})
                               : ((deg_a_rd_r >= DEG_MAX) || (deg_b_rd_r >= DEG_MAX));
  assign push_ok   = (sp_r < STACK_CAP);
  assign sp_dec    = sp_r - 1'b1;

  assign sts.kind        = in_word.kind;
  assign sts.sweep_last  = (sweep_r == SWEEP_LAST);
  assign sts.n_zero      = (n_use == '0);
  assign sts.edge_bad    = range_bad || deg_bad;
  assign sts.stack_empty = (sp_r == '0);
  assign sts.slot_end    = (slot_r == deg_a_rd_r);
  assign sts.nbr_skip    = (NW'(nbr_rd_r) >= NW'(n_use));
  assign sts.nbr_visited = mark_rd_r[PW];
  assign sts.nbr_parent  = (par_r == PW'(nbr_rd_r));

  always_comb begin
    deg_we = 1'b0;
    deg_wa = sweep_r;
    deg_wd = '0;
    priority if (cmd.sweep && cmd.sweep_deg) begin
      deg_we = 1'b1;
    end else if (cmd.edge_w1) begin
      deg_we = 1'b1;
      deg_wa = vtx_a;
      deg_wd = DGW'(deg_a_rd_r + 1'b1);
    end else if (cmd.edge_w2) begin
      deg_we = 1'b1;
      deg_wa = vtx_b;
      deg_wd = DGW'(deg_b_eff + 1'b1);
    end else begin
      deg_we = 1'b0;
    end
  end

  assign deg_ra = cmd.fetch ? stk_rd_r : VW'(in_word.vertex_a);

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    if (cmd.load || cmd.fetch) deg_a_rd_r <= deg_mem[deg_ra];
    if (cmd.load) deg_b_rd_r <= deg_mem[VW'(in_word.vertex_b)];
  end

  always_comb begin
    nbr_we = cmd.edge_w1 || cmd.edge_w2;
    if (cmd.edge_w2) begin
      nbr_wa = NA'(vtx_b) * DEG_STRIDE + NA'(deg_b_eff);
      nbr_wd = vtx_a;
    end else begin
      nbr_wa = NA'(vtx_a) * DEG_STRIDE + NA'(deg_a_rd_r);
      nbr_wd = vtx_b;
    end
  end

  assign nbr_ra = NA'(stk_rd_r) * DEG_STRIDE + NA'(slot_r);

  always_ff @(posedge clk) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    if (cmd.nread) nbr_rd_r <= nbr_mem[nbr_ra];
  end

  always_comb begin
    mark_we = 1'b0;
    mark_wa = sweep_r;
    mark_wd = '0;
    priority if (cmd.sweep && cmd.sweep_mark) begin
      mark_we = 1'b1;
    end else if (cmd.root) begin
      mark_we = 1'b1;
      mark_wa = '0;
      mark_wd = {1'b1, NO_PARENT};
    end else if (cmd.visit) begin
      mark_we = 1'b1;
      mark_wa = nbr_rd_r;
      mark_wd = {1'b1, PW'(stk_rd_r)};
    end else begin
      mark_we = 1'b0;
    end
  end

  assign mark_ra = cmd.mread ? nbr_rd_r : stk_rd_r;

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (cmd.fetch || cmd.mread) mark_rd_r <= mark_mem[mark_ra];
  end

  always_comb begin
    stk_we = 1'b0;
    stk_wa = sp_r[VW-1:0];
    stk_wd = nbr_rd_r;
    priority if (cmd.root) begin
      stk_we = 1'b1;
      stk_wa = '0;
      stk_wd = '0;
    end else if (cmd.visit && push_ok) begin
      stk_we = 1'b1;
    end else begin
      stk_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    if (cmd.pop) stk_rd_r <= stack_mem[sp_dec[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= '0;
      err_r       <= 1'b0;
      sweep_r     <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) vcount_r <= cfg_data;
      if (cmd.set_err) begin
        err_r <= 1'b1;
      end else if (cmd.clr_err) begin
        err_r <= 1'b0;
      end
      if (cmd.sweep) sweep_r <= sts.sweep_last ? '0 : VW'(sweep_r + 1'b1);
      if (cmd.root) begin
        sp_r <= PW'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_dec;
      end else if (cmd.visit && push_ok) begin
        sp_r <= PW'(sp_r + 1'b1);
      end
      out_valid_r <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_word.vertex_a;
      b_r <= in_word.vertex_b;
    end
    if (cmd.take_par) begin
      par_r  <= mark_rd_r[PW-1:0];
      slot_r <= '0;
    end else if (cmd.nread) begin
      slot_r <= DGW'(slot_r + 1'b1);
    end
    if (cmd.report) begin
      out_word_r.has_cycle  <= cmd.found;
      out_word_r.load_error <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: sv/undirected_cycle_detect_unit.sv
// ----------------------------------------------------------------------------
// Undirected cycle detect unit
// Add edge: busy in E1 and E2 after the accepting edge, in E1 alone when dropped.
// Clear: a degree sweep. Check: a mark clearing sweep and a root step, then POP, FETCH,
// PINFO and NREAD per popped vertex, up to NREAD, NCHK and VIS per neighbour slot, and
// a final POP on the empty stack; the strobe follows the last walk step in the next cycle.
// Zero vertices: result strobe in the cycle after the accepting edge.
// Reset: a clearing pass over all vertices with busy high; config taken always.
// ----------------------------------------------------------------------------
module undirected_cycle_detect_unit #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  ucd_pkg::in_word_t       in_word,
  output logic                    out_valid,
  output ucd_pkg::out_word_t      out_word,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ucd_pkg::VCW-1:0] cfg_data
);
  import ucd_pkg::*;

  ucd_cmd_t cmd;
  ucd_sts_t sts;

  assign cfg_ready = 1'b1;

  ucd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ucd_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: sv/ucd_checker.sv
// ----------------------------------------------------------------------------
// Cycle detect port checker
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ucd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input ucd_pkg::in_word_t in_word,
  input logic              out_valid
);
  import ucd_pkg::*;

  logic in_take;
  logic take_other;
  logic take_load;
  logic take_check;

  assign in_take    = start && !busy;
  assign take_other = in_take && (in_word.kind != KIND_CHECK);
  assign take_load  = in_take && (in_word.kind == KIND_ADD || in_word.kind == KIND_CLEAR);
  assign take_check = start && (in_word.kind == KIND_CHECK);

  `ASSERT_ALWAYS(a_busy_after_reset, !rst_n |=> busy, "not busy after reset")
  `ASSERT_RUN(a_idle_on_result, out_valid |-> !busy, "result while busy")
  `ASSERT_RUN(a_no_result_for_load, take_other |=> !out_valid, "result for a non-check word")
  `ASSERT_RUN(a_busy_after_load, take_load |=> busy, "load or clear not taken")
  `ASSERT_RUN(a_result_has_cause, out_valid |-> $past(busy) || $past(take_check), "stray result")

endmodule

bind undirected_cycle_detect_unit ucd_checker u_ucd_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Cycle detect unit testbench
// Loads undirected graphs word by word into the unit and checks every cycle
// verdict against a local depth-first predictor or, for a short stimulus table
// of extremes and corner cases, the typed verdict; random trees, hubs, loops and
// noise follow, with vertex count changes between phases and sender idle bursts.
// ----------------------------------------------------------------------------
module tb;
  import ucd_pkg::*;

  localparam int unsigned MAX_VERTICES  = 1024;
  localparam int unsigned MAX_DEGREE    = 16;
  localparam int unsigned NO_PARENT     = MAX_VERTICES;
  localparam int unsigned RANDOM_WORDS  = 600;
  localparam int unsigned QUIET_TAIL    = 100;
  localparam int unsigned SETTLE_CYCLES = MAX_VERTICES + 8;
  localparam longint unsigned RUN_LIMIT = 24_000_000;
  localparam logic [KW-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    bit             is_cfg;
    logic [VCW-1:0] value;
    logic [KW-1:0]  kind;
    logic [VIW-1:0] a;
    logic [VIW-1:0] b;
    int             reps;
    bit             typed;
    out_word_t      want;
  } plan_row_t;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           start     = 1'b0;
  logic           busy;
  in_word_t       in_word   = '0;
  logic           out_valid;
  out_word_t      out_word;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [VCW-1:0] cfg_data  = '0;

  logic [VIW-1:0] adj_store [MAX_VERTICES*MAX_DEGREE];
  int unsigned    adj_degree [MAX_VERTICES];
  bit             walk_mark [MAX_VERTICES];
  int unsigned    walk_parent [MAX_VERTICES];
  int unsigned    walk_stack [MAX_VERTICES];
  bit             load_error_flag = 1'b0;
  logic [VCW-1:0] vertex_count = '0;

  out_word_t   expected_verdicts [$];
  out_word_t   oldest_verdict;
  int unsigned mismatches       = 0;
  int unsigned verdicts_checked = 0;
  int unsigned words_sent       = 0;
  int unsigned checks_sent      = 0;
  int unsigned count_settings   = 0;
  bit          sender_idles     = 1'b1;

  plan_row_t directed_plan [29] = '{
    '{1'b1, 11'd0,    KIND_ADD,    10'd0,    10'd0,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd0,    10'd0,    1, 1'b1, '{1'b1, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd0,    10'd0,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd1023, 10'd1023, 1, 1'b1, '{1'b1, 1'b1}},
    '{1'b0, 11'd0,    KIND_CLEAR,  10'd0,    10'd0,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 11'd2047, KIND_ADD,    10'd0,    10'd0,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd0,    10'd0,    1, 1'b1, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd1023, 10'd0,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd0,    10'd1023, 1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd0,    10'd0,    1, 1'b1, '{1'b1, 1'b0}},
    '{1'b0, 11'd0,    KIND_CLEAR,  10'd1023, 10'd1023, 1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd0,    10'd1,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd1,    10'd2,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd0,    10'd0,    1, 1'b1, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd2,    10'd2,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd0,    10'd0,    1, 1'b1, '{1'b1, 1'b0}},
    '{1'b0, 11'd0,    KIND_UNUSED, 10'd1023, 10'd1023, 1, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 11'd2,    KIND_ADD,    10'd0,    10'd0,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd0,    10'd0,    1, 1'b1, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd0,    10'd2,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd0,    10'd0,    1, 1'b1, '{1'b0, 1'b1}},
    '{1'b0, 11'd0,    KIND_CLEAR,  10'd0,    10'd0,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 11'd1024, KIND_ADD,    10'd0,    10'd0,    1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd1023, 10'd1023, 1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd5,    10'd5,    9, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd0,    10'd0,    1, 1'b1, '{1'b0, 1'b1}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd0,    10'd682,  1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_ADD,    10'd682,  10'd341,  1, 1'b0, '{1'b0, 1'b0}},
    '{1'b0, 11'd0,    KIND_CHECK,  10'd341,  10'd682,  1, 1'b0, '{1'b0, 1'b0}}
  };

  undirected_cycle_detect_unit #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_DEGREE  (MAX_DEGREE)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned vertices_in_use();
    return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
  endfunction

  function automatic void record_edge(int unsigned a, int unsigned b);
    int unsigned n;
    bit full;
    n = vertices_in_use();
    if (a >= n || b >= n) begin
      load_error_flag = 1'b1;
      return;
    end
    if (a == b) full = adj_degree[a] + 2 > MAX_DEGREE;
    else full = adj_degree[a] >= MAX_DEGREE || adj_degree[b] >= MAX_DEGREE;
    if (full) begin
      load_error_flag = 1'b1;
      return;
    end
    adj_store[a*MAX_DEGREE + adj_degree[a]] = VIW'(b);
    adj_degree[a]++;
    adj_store[b*MAX_DEGREE + adj_degree[b]] = VIW'(a);
    adj_degree[b]++;
  endfunction

  function automatic bit cycle_reachable();
    int unsigned n, depth, v, nb, slots;
    n = vertices_in_use();
    if (n == 0) return 1'b1;
    foreach (walk_mark[x]) walk_mark[x] = 1'b0;
    walk_stack[0]  = 0;
    depth          = 1;
    walk_mark[0]   = 1'b1;
    walk_parent[0] = NO_PARENT;
    while (depth > 0) begin
      depth--;
      v = walk_stack[depth];
      slots = (adj_degree[v] > MAX_DEGREE) ? MAX_DEGREE : adj_degree[v];
      for (int unsigned k = 0; k < slots; k++) begin
        nb = 32'(adj_store[v*MAX_DEGREE + k]);
        if (nb < n) begin
          if (!walk_mark[nb]) begin
            walk_parent[nb] = v;
            walk_mark[nb]   = 1'b1;
            if (depth < MAX_VERTICES) begin
              walk_stack[depth] = nb;
              depth++;
            end
          end else if (walk_parent[v] != nb) begin
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit apply_word(in_word_t w, output out_word_t verdict);
    verdict = '0;
    case (w.kind)
      KIND_ADD: record_edge(32'(w.vertex_a), 32'(w.vertex_b));
      KIND_CHECK: begin
        verdict.has_cycle  = cycle_reachable();
        verdict.load_error = load_error_flag;
        return 1'b1;
      end
      KIND_CLEAR: begin
        foreach (adj_degree[x]) adj_degree[x] = 0;
        load_error_flag = 1'b0;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int unsigned pick_vertex();
    int unsigned n;
    n = vertices_in_use();
    return (n == 0) ? $urandom_range(0, MAX_VERTICES - 1) : $urandom_range(0, n - 1);
  endfunction

  function automatic int unsigned node_vertex(int unsigned base, int unsigned idx);
    return (idx == 0) ? 0 : base + idx - 1;
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t typed_verdict);
    out_word_t verdict;
    @(negedge clk);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start   = 1'b1;
    in_word = w;
    do @(posedge clk); while (busy);
    if (apply_word(w, verdict)) begin
      expected_verdicts.insert(expected_verdicts.size(), typed ? typed_verdict : verdict);
      checks_sent++;
    end
    if (w.kind != KIND_UNUSED) words_sent++;
  endtask

  task automatic send_op(logic [KW-1:0] kind, int unsigned a, int unsigned b);
    in_word_t w;
    w = '{kind, VIW'(a), VIW'(b)};
    send_word(w, 1'b0, '0);
  endtask

  task automatic hold_sender_until_drained();
    @(negedge clk);
    start = 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [VCW-1:0] value);
    hold_sender_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    vertex_count = value;
    count_settings++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict with none pending: expected none, actual %b", $time, out_word);
        mismatches++;
      end else begin
        oldest_verdict = expected_verdicts.pop_front();
        verdicts_checked++;
        if (out_word.has_cycle !== oldest_verdict.has_cycle) begin
          $display("%0t: has_cycle expected %b actual %b", $time,
                   oldest_verdict.has_cycle, out_word.has_cycle);
          mismatches++;
        end
        if (out_word.load_error !== oldest_verdict.load_error) begin
          $display("%0t: load_error expected %b actual %b", $time,
                   oldest_verdict.load_error, out_word.load_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_word_t       w;
    logic [VCW-1:0] count;
    int unsigned    n, span, base, hub, p, v, directed_words;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_cfg) begin
        write_vertex_count(directed_plan[r].value);
      end else begin
        w = '{directed_plan[r].kind, directed_plan[r].a, directed_plan[r].b};
        repeat (directed_plan[r].reps) send_word(w, directed_plan[r].typed, directed_plan[r].want);
      end
    end
    directed_words = words_sent;

    while (words_sent < directed_words + RANDOM_WORDS) begin
      case ($urandom_range(0, 15))
        0: count = '0;
        1: count = 11'd1;
        2: count = VCW'(MAX_VERTICES);
        3: count = '1;
        4: count = VCW'($urandom_range(0, 2047));
        5, 6: count = VCW'($urandom_range(2, MAX_VERTICES));
        default: count = VCW'($urandom_range(2, 40));
      endcase
      write_vertex_count(count);
      sender_idles = (words_sent + QUIET_TAIL < directed_words + RANDOM_WORDS) &&
                     ($urandom_range(0, 2) != 0);
      n = vertices_in_use();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) != 0) send_op(KIND_CLEAR, $urandom, $urandom);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            span = (n < 14) ? n : $urandom_range(2, 14);
            base = (span >= 2) ? $urandom_range(1, n - span + 1) : 1;
            for (int unsigned k = 1; k < span; k++) begin
              p = $urandom_range(0, k - 1);
              if ($urandom_range(0, 1))
                send_op(KIND_ADD, node_vertex(base, k), node_vertex(base, p));
              else
                send_op(KIND_ADD, node_vertex(base, p), node_vertex(base, k));
            end
            if (span >= 2 && $urandom_range(0, 1))
              send_op(KIND_ADD, node_vertex(base, $urandom_range(0, span - 1)),
                      node_vertex(base, $urandom_range(0, span - 1)));
          end
          4, 5: repeat ($urandom_range(1, 10)) send_op(KIND_ADD, pick_vertex(), pick_vertex());
          6: begin
            hub = pick_vertex();
            repeat ($urandom_range(15, 18)) send_op(KIND_ADD, hub, pick_vertex());
          end
          7: repeat ($urandom_range(3, 8))
            send_op(KW'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom_range(0, 1023));
          8: begin
            v = pick_vertex();
            send_op(KIND_ADD, 0, v);
            if ($urandom_range(0, 1)) send_op(KIND_ADD, v, v);
            else send_op(KIND_ADD, v, 0);
          end
          default: begin
            send_op(KIND_ADD, 0, pick_vertex());
            repeat ($urandom_range(1, 4))
              send_op(KIND_ADD, pick_vertex(),
                      (n < MAX_VERTICES) ? $urandom_range(n, MAX_VERTICES - 1) : pick_vertex());
          end
        endcase
        send_op(KIND_CHECK, $urandom, $urandom);
        if ($urandom_range(0, 7) == 0) hold_sender_until_drained();
      end
    end

    hold_sender_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d words including %0d cycle checks; %0d verdicts compared",
             words_sent, checks_sent, verdicts_checked);
    $display("Covered %0d vertex-count settings: trees, loops, hubs, range errors, noise",
             count_settings);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/ucd_pkg.sv
sv/ucd_ctrl.sv
sv/ucd_dp.sv
sv/undirected_cycle_detect_unit.sv
sv/ucd_checker.sv
tb/tb.sv
